### hw/rtl/tfdm_pkg.sv
// Shared types, constants and the luma function of the tiled frame difference motion block.
`default_nettype none

package tfdm_pkg;

	// Configuration register widths and reset values.
	localparam int THR_W      = 8;
	localparam int SIZE_W     = 9;
	localparam int CFG_W      = 9;
	localparam int CFG_IDX_W  = 2;

	localparam logic [THR_W-1:0]  THR_RESET  = 8'd16;
	localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_THRESHOLD = 2'd0,
		CFG_COLUMNS   = 2'd1,
		CFG_ROWS      = 2'd2
	} cfg_idx_t;

	// Luma weights and rounding term.
	localparam logic [15:0] LUMA_R     = 16'd77;
	localparam logic [15:0] LUMA_G     = 16'd150;
	localparam logic [15:0] LUMA_B     = 16'd29;
	localparam logic [15:0] LUMA_ROUND = 16'd128;

	// Per-pixel position flags handed from the scan stage to the evaluation stage.
	typedef struct packed {
		logic frame_first;
		logic frame_end;
		logic tile_first;
		logic tile_end;
		logic have_prev;
		logic result;
	} pix_flags_t;

	// Weighted sum of the three components, rounded and scaled back to eight bits.
	function automatic logic [7:0] luma_of(input logic [7:0] r, input logic [7:0] g,
		input logic [7:0] b);
		logic [15:0] sum;
		sum = LUMA_R * {8'd0, r} + LUMA_G * {8'd0, g} + LUMA_B * {8'd0, b} + LUMA_ROUND;
		return sum[15:8];
	endfunction

endpackage

`default_nettype wire

### hw/rtl/tiled_frame_difference_motion.sv
// Top level of the tiled frame difference motion detector.
`default_nettype none

// Takes one RGB pixel per clock in raster order and compares its luma with the
// pixel at the same place in the previous frame, held in a MAX_COLUMNS x MAX_ROWS
// byte RAM that is read and rewritten in the cycle the pixel is taken. Changed
// pixels outside detection boxes are counted per tile in a small tile RAM that is
// read in the accept cycle and written back in the cycle after, with a forwarding
// register covering back-to-back pixels of the same tile. From the second frame on,
// one transaction leaves through the stage-one and result registers after the last
// pixel of each frame. A pixel that ends a frame waits while an earlier frame's
// transaction is still held or one stage ahead; with frames of over two pixels and
// no result stall the rate is one pixel per clock. No clearing pass follows reset;
// a change of frame size starts over with a frame that only fills the luma RAM.
module tiled_frame_difference_motion #(
	parameter int MAX_COLUMNS = 256,
	parameter int MAX_ROWS    = 256,
	parameter int TILE_SIZE   = 8
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             cfg_write,
	input  wire [tfdm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire [tfdm_pkg::CFG_W-1:0]       cfg_data,
	input  wire                             in_valid,
	output logic                            in_stall,
	input  wire [7:0]                       red,
	input  wire [7:0]                       green,
	input  wire [7:0]                       blue,
	input  wire                             inside_box,
	input  wire                             frame_start,
	output logic                            out_valid,
	input  wire                             out_stall,
	output logic                            request_detection,
	output logic                            tile_triggered,
	output logic                            frame_triggered
);

	localparam int CW         = $clog2(MAX_COLUMNS + 1);
	localparam int RW         = $clog2(MAX_ROWS + 1);
	localparam int AW         = $clog2(MAX_COLUMNS * MAX_ROWS);
	localparam int TILE_SLOTS = (MAX_COLUMNS + TILE_SIZE - 1) / TILE_SIZE;
	localparam int SW         = (TILE_SLOTS > 1) ? $clog2(TILE_SLOTS) : 1;
	localparam int TSW        = $clog2(TILE_SIZE + 1);
	localparam int TCW        = $clog2(TILE_SIZE * TILE_SIZE + 1);
	localparam int FCW        = $clog2(MAX_COLUMNS * MAX_ROWS + 1);
	localparam int CMPC       = (CW > tfdm_pkg::SIZE_W) ? CW : tfdm_pkg::SIZE_W;
	localparam int CMPR       = (RW > tfdm_pkg::SIZE_W) ? RW : tfdm_pkg::SIZE_W;

	logic [tfdm_pkg::THR_W-1:0]  thr_q;
	logic [tfdm_pkg::SIZE_W-1:0] cols_cfg_q, rows_cfg_q;
	logic [CW-1:0]               cols_eff;
	logic [RW-1:0]               rows_eff;
	logic [CW+RW-1:0]            area_full;
	logic [FCW-1:0]              area_q;
	logic                        size_clr;
	logic                        accept;
	logic                        busy;

	logic [7:0]                  luma;
	logic [AW-1:0]               luma_addr;
	logic [SW-1:0]               slot;
	logic [TSW-1:0]              tile_w, tile_h;
	tfdm_pkg::pix_flags_t        flags;
	logic [7:0]                  old_luma;
	logic [TCW-1:0]              tile_rd_data;
	logic                        tile_wr_en;
	logic [SW-1:0]               tile_wr_addr;
	logic [TCW-1:0]              tile_wr_data;

	// A size write that changes the value starts the frame history over.
	assign size_clr = cfg_write &&
		(((cfg_index == tfdm_pkg::CFG_COLUMNS) && (cfg_data != cols_cfg_q)) ||
		 ((cfg_index == tfdm_pkg::CFG_ROWS) && (cfg_data != rows_cfg_q)));

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q      <= tfdm_pkg::THR_RESET;
			cols_cfg_q <= tfdm_pkg::SIZE_RESET;
			rows_cfg_q <= tfdm_pkg::SIZE_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				tfdm_pkg::CFG_THRESHOLD: begin
					thr_q <= cfg_data[tfdm_pkg::THR_W-1:0];
				end
				tfdm_pkg::CFG_COLUMNS: begin
					cols_cfg_q <= cfg_data;
				end
				tfdm_pkg::CFG_ROWS: begin
					rows_cfg_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	// Sizes in use: zero counts as one, anything beyond the maximum as the maximum.
	always_comb begin
		if (cols_cfg_q == '0) begin
			cols_eff = CW'(1);
		end else if (CMPC'(cols_cfg_q) > CMPC'(MAX_COLUMNS)) begin
			cols_eff = CW'(MAX_COLUMNS);
		end else begin
			cols_eff = CW'(cols_cfg_q);
		end
		if (rows_cfg_q == '0) begin
			rows_eff = RW'(1);
		end else if (CMPR'(rows_cfg_q) > CMPR'(MAX_ROWS)) begin
			rows_eff = RW'(MAX_ROWS);
		end else begin
			rows_eff = RW'(rows_cfg_q);
		end
	end

	// Pixel count of a whole frame, registered off the configuration.
	assign area_full = (CW+RW)'(cols_eff) * (CW+RW)'(rows_eff);

	always_ff @(posedge clk) begin
		area_q <= FCW'(area_full);
	end

	assign in_stall = flags.result && busy;
	assign accept   = in_valid && !in_stall;

	tfdm_scan #(
		.MAX_COLUMNS (MAX_COLUMNS),
		.MAX_ROWS    (MAX_ROWS),
		.TILE_SIZE   (TILE_SIZE)
	) u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.size_clr    (size_clr),
		.frame_start (frame_start),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.cols_eff    (cols_eff),
		.rows_eff    (rows_eff),
		.luma        (luma),
		.luma_addr   (luma_addr),
		.slot        (slot),
		.tile_w      (tile_w),
		.tile_h      (tile_h),
		.flags       (flags)
	);

	// Previous frame luma: the old value is read while the new one is written.
	tfdm_ram #(
		.WIDTH (8),
		.DEPTH (MAX_COLUMNS * MAX_ROWS)
	) u_luma_ram (
		.clk     (clk),
		.wr_en   (accept),
		.wr_addr (luma_addr),
		.wr_data (luma),
		.rd_en   (accept),
		.rd_addr (luma_addr),
		.rd_data (old_luma)
	);

	// Per-tile counts of changed pixels outside the boxes for the current tile row.
	tfdm_ram #(
		.WIDTH (TCW),
		.DEPTH (TILE_SLOTS)
	) u_tile_ram (
		.clk     (clk),
		.wr_en   (tile_wr_en),
		.wr_addr (tile_wr_addr),
		.wr_data (tile_wr_data),
		.rd_en   (accept),
		.rd_addr (slot),
		.rd_data (tile_rd_data)
	);

	tfdm_eval #(
		.MAX_COLUMNS (MAX_COLUMNS),
		.MAX_ROWS    (MAX_ROWS),
		.TILE_SIZE   (TILE_SIZE)
	) u_eval (
		.clk               (clk),
		.arst_n            (arst_n),
		.accept            (accept),
		.luma              (luma),
		.inside_box        (inside_box),
		.slot              (slot),
		.tile_w            (tile_w),
		.tile_h            (tile_h),
		.flags             (flags),
		.threshold         (thr_q),
		.area              (area_q),
		.old_luma          (old_luma),
		.tile_rd_data      (tile_rd_data),
		.tile_wr_en        (tile_wr_en),
		.tile_wr_addr      (tile_wr_addr),
		.tile_wr_data      (tile_wr_data),
		.busy              (busy),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.request_detection (request_detection),
		.tile_triggered    (tile_triggered),
		.frame_triggered   (frame_triggered)
	);

endmodule

`default_nettype wire

### hw/rtl/tfdm_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
`default_nettype none

module tfdm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire                 clk,
	input  wire                 wr_en,
	input  wire [AW-1:0]        wr_addr,
	input  wire [WIDTH-1:0]     wr_data,
	input  wire                 rd_en,
	input  wire [AW-1:0]        rd_addr,
	output logic [WIDTH-1:0]    rd_data
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] mem_q [DEPTH];

	// A read of the address being written returns the old contents.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

### hw/rtl/tfdm_scan.sv
// Scan stage: raster position, tile position, memory addresses and luma of the incoming pixel.
`default_nettype none

module tfdm_scan #(
	parameter int MAX_COLUMNS = 256,
	parameter int MAX_ROWS    = 256,
	parameter int TILE_SIZE   = 8
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     accept,
	input  wire                     size_clr,
	input  wire                     frame_start,
	input  wire [7:0]               red,
	input  wire [7:0]               green,
	input  wire [7:0]               blue,
	input  wire [CW-1:0]            cols_eff,
	input  wire [RW-1:0]            rows_eff,
	output logic [7:0]              luma,
	output logic [AW-1:0]           luma_addr,
	output logic [SW-1:0]           slot,
	output logic [TSW-1:0]          tile_w,
	output logic [TSW-1:0]          tile_h,
	output tfdm_pkg::pix_flags_t    flags
);

	localparam int CW         = $clog2(MAX_COLUMNS + 1);
	localparam int RW         = $clog2(MAX_ROWS + 1);
	localparam int CIW        = $clog2(MAX_COLUMNS);
	localparam int RIW        = $clog2(MAX_ROWS);
	localparam int AW         = $clog2(MAX_COLUMNS * MAX_ROWS);
	localparam int TILE_SLOTS = (MAX_COLUMNS + TILE_SIZE - 1) / TILE_SIZE;
	localparam int SW         = (TILE_SLOTS > 1) ? $clog2(TILE_SLOTS) : 1;
	localparam int TIW        = $clog2(TILE_SIZE);
	localparam int TSW        = $clog2(TILE_SIZE + 1);

	logic [CIW-1:0] col_q, col;
	logic [RIW-1:0] row_q, row;
	logic [TIW-1:0] cit_q, cit;
	logic [TIW-1:0] rit_q, rit;
	logic [SW-1:0]  slot_q;
	logic [AW-1:0]  row_base_q, row_base;
	logic           have_prev_q;
	logic           restart;
	logic           last_col, last_row;
	logic           cit_wrap, rit_wrap;
	logic [CW-1:0]  col_rem;
	logic [RW-1:0]  row_rem;

	// A frame start or a position outside the current size begins a new frame.
	assign restart = frame_start || (CW'(col_q) >= cols_eff) || (RW'(row_q) >= rows_eff);

	assign col      = restart ? '0 : col_q;
	assign row      = restart ? '0 : row_q;
	assign cit      = restart ? '0 : cit_q;
	assign rit      = restart ? '0 : rit_q;
	assign slot     = restart ? '0 : slot_q;
	assign row_base = restart ? '0 : row_base_q;

	assign last_col = (CW'(col) == cols_eff - CW'(1));
	assign last_row = (RW'(row) == rows_eff - RW'(1));
	assign cit_wrap = (cit == TIW'(TILE_SIZE - 1));
	assign rit_wrap = (rit == TIW'(TILE_SIZE - 1));

	// Real extent of the current tile, shorter at the right and bottom edges.
	assign col_rem = cols_eff - CW'(col) + CW'(cit);
	assign row_rem = rows_eff - RW'(row) + RW'(rit);
	assign tile_w  = (32'(col_rem) < 32'(TILE_SIZE)) ? TSW'(col_rem) : TSW'(TILE_SIZE);
	assign tile_h  = (32'(row_rem) < 32'(TILE_SIZE)) ? TSW'(row_rem) : TSW'(TILE_SIZE);

	assign luma      = tfdm_pkg::luma_of(red, green, blue);
	assign luma_addr = row_base + AW'(col);

	// Position flags for the evaluation stage.
	always_comb begin
		flags.frame_first = (col == '0) && (row == '0);
		flags.frame_end   = last_col && last_row;
		flags.tile_first  = (cit == '0) && (rit == '0);
		flags.tile_end    = (cit_wrap || last_col) && (rit_wrap || last_row);
		flags.have_prev   = have_prev_q;
		flags.result      = last_col && last_row && have_prev_q;
	end

	// Advance the raster and tile positions by one pixel per transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			row_q       <= '0;
			cit_q       <= '0;
			rit_q       <= '0;
			slot_q      <= '0;
			row_base_q  <= '0;
			have_prev_q <= 1'b0;
		end else if (size_clr) begin
			col_q       <= '0;
			row_q       <= '0;
			cit_q       <= '0;
			rit_q       <= '0;
			slot_q      <= '0;
			row_base_q  <= '0;
			have_prev_q <= 1'b0;
		end else if (accept) begin
			if (last_col && last_row) begin
				col_q       <= '0;
				row_q       <= '0;
				cit_q       <= '0;
				rit_q       <= '0;
				slot_q      <= '0;
				row_base_q  <= '0;
				have_prev_q <= 1'b1;
			end else if (last_col) begin
				col_q      <= '0;
				cit_q      <= '0;
				slot_q     <= '0;
				row_q      <= row + RIW'(1);
				rit_q      <= rit_wrap ? '0 : rit + TIW'(1);
				row_base_q <= row_base + AW'(MAX_COLUMNS);
			end else begin
				col_q      <= col + CIW'(1);
				cit_q      <= cit_wrap ? '0 : cit + TIW'(1);
				slot_q     <= cit_wrap ? slot + SW'(1) : slot;
				row_q      <= row;
				rit_q      <= rit;
				row_base_q <= row_base;
			end
		end
	end

endmodule

`default_nettype wire

### hw/rtl/tfdm_eval.sv
// Evaluation stage: luma difference, tile count update with write-back, frame totals and result register.
`default_nettype none

module tfdm_eval #(
	parameter int MAX_COLUMNS = 256,
	parameter int MAX_ROWS    = 256,
	parameter int TILE_SIZE   = 8
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     accept,
	input  wire [7:0]               luma,
	input  wire                     inside_box,
	input  wire [SW-1:0]            slot,
	input  wire [TSW-1:0]           tile_w,
	input  wire [TSW-1:0]           tile_h,
	input  tfdm_pkg::pix_flags_t    flags,
	input  wire [tfdm_pkg::THR_W-1:0] threshold,
	input  wire [FCW-1:0]           area,
	input  wire [7:0]               old_luma,
	input  wire [TCW-1:0]           tile_rd_data,
	output logic                    tile_wr_en,
	output logic [SW-1:0]           tile_wr_addr,
	output logic [TCW-1:0]          tile_wr_data,
	output logic                    busy,
	output logic                    out_valid,
	input  wire                     out_stall,
	output logic                    request_detection,
	output logic                    tile_triggered,
	output logic                    frame_triggered
);

	localparam int TILE_SLOTS = (MAX_COLUMNS + TILE_SIZE - 1) / TILE_SIZE;
	localparam int SW         = (TILE_SLOTS > 1) ? $clog2(TILE_SLOTS) : 1;
	localparam int TSW        = $clog2(TILE_SIZE + 1);
	localparam int TCW        = $clog2(TILE_SIZE * TILE_SIZE + 1);
	localparam int FCW        = $clog2(MAX_COLUMNS * MAX_ROWS + 1);

	// Stage one pipeline registers.
	logic                   vld_s1;
	logic [7:0]             luma_s1;
	logic                   inside_s1;
	logic [SW-1:0]          slot_s1;
	logic [TSW-1:0]         tile_w_s1;
	logic [TSW-1:0]         tile_h_s1;
	tfdm_pkg::pix_flags_t   flags_s1;

	// Forwarding of the tile count written in the previous cycle.
	logic                   fwd_vld_q;
	logic [SW-1:0]          fwd_slot_q;
	logic [TCW-1:0]         fwd_cnt_q;

	// Running frame totals.
	logic [FCW-1:0]         frame_cnt_q;
	logic                   tile_hit_q;

	logic                   out_vld_q;
	logic                   tile_q, frame_q;

	logic [7:0]             diff;
	logic                   changed;
	logic [TCW-1:0]         cnt_base, cnt_new;
	logic [2*TSW-1:0]       tile_area;
	logic                   tile_hit;
	logic [FCW-1:0]         frame_new;
	logic [FCW+1:0]         frame_x3;
	logic                   hit_new;
	logic                   frame_hit;
	logic                   emit;

	always_ff @(posedge clk) begin
		luma_s1   <= luma;
		inside_s1 <= inside_box;
		slot_s1   <= slot;
		tile_w_s1 <= tile_w;
		tile_h_s1 <= tile_h;
		flags_s1  <= flags;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
		end
	end

	// Absolute difference against the stored luma of the previous frame.
	assign diff    = (old_luma > luma_s1) ? (old_luma - luma_s1) : (luma_s1 - old_luma);
	assign changed = flags_s1.have_prev && (diff >= threshold);

	// A tile count starts from zero at the first pixel of its tile.
	always_comb begin
		if (flags_s1.tile_first) begin
			cnt_base = '0;
		end else if (fwd_vld_q && (fwd_slot_q == slot_s1)) begin
			cnt_base = fwd_cnt_q;
		end else begin
			cnt_base = tile_rd_data;
		end
	end

	assign cnt_new   = cnt_base + TCW'(changed && !inside_s1);
	assign tile_area = (2*TSW)'(tile_w_s1) * (2*TSW)'(tile_h_s1);
	assign tile_hit  = flags_s1.tile_end && flags_s1.have_prev &&
		(32'({cnt_new, 2'b00}) >= 32'(tile_area));

	assign tile_wr_en   = vld_s1;
	assign tile_wr_addr = slot_s1;
	assign tile_wr_data = flags_s1.tile_end ? '0 : cnt_new;

	// Frame totals restart at the first pixel of each frame.
	assign frame_new = (flags_s1.frame_first ? '0 : frame_cnt_q) + FCW'(changed);
	assign hit_new   = (flags_s1.frame_first ? 1'b0 : tile_hit_q) || tile_hit;
	assign frame_x3  = {frame_new, 1'b0} + (FCW+2)'(frame_new);
	assign frame_hit = (frame_x3 >= (FCW+2)'(area));
	assign emit      = vld_s1 && flags_s1.result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_vld_q   <= 1'b0;
			frame_cnt_q <= '0;
			tile_hit_q  <= 1'b0;
		end else begin
			fwd_vld_q <= vld_s1;
			if (vld_s1) begin
				frame_cnt_q <= frame_new;
				tile_hit_q  <= hit_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		fwd_slot_q <= slot_s1;
		fwd_cnt_q  <= tile_wr_data;
	end

	// Result register; the scan side holds off a result pixel while this one is occupied.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (emit) begin
			out_vld_q <= 1'b1;
		end else if (!out_stall) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			tile_q  <= hit_new;
			frame_q <= frame_hit;
		end
	end

	assign busy              = out_vld_q || emit;
	assign out_valid         = out_vld_q;
	assign tile_triggered    = tile_q;
	assign frame_triggered   = frame_q;
	assign request_detection = tile_q || frame_q;

endmodule

`default_nettype wire

### test/tb_tiled_frame_difference_motion.sv
// Self-checking testbench for the tiled frame difference motion detector.
module tb_tiled_frame_difference_motion;
	timeunit 1ns;
	timeprecision 1ps;

	import tfdm_pkg::*;

	localparam int MAX_COLUMNS  = 256;
	localparam int MAX_ROWS     = 256;
	localparam int TILE         = 8;
	localparam int TILE_SLOTS   = (MAX_COLUMNS + TILE - 1) / TILE;
	localparam int ITEM_TARGET  = 1900;
	localparam int RESULT_FLOOR = 48;
	localparam int LONG_HOLD    = 300;
	localparam int DRAIN_CYCLES = 8;
	localparam int MAX_REPORTS  = 10;

	// Flags carried by one result transaction.
	typedef struct packed {
		logic request_detection;
		logic tile_triggered;
		logic frame_triggered;
	} motion_flags_t;

	// Tracks the detector state per accepted pixel and holds the flags still owed.
	class motion_flag_tracker;
		int unsigned   threshold;
		logic [8:0]    columns_reg;
		logic [8:0]    rows_reg;
		logic [7:0]    luma_store [MAX_COLUMNS*MAX_ROWS];
		bit            have_prev;
		int unsigned   tile_count [TILE_SLOTS];
		int unsigned   frame_count;
		int unsigned   col_pos;
		int unsigned   row_pos;
		bit            tile_hit;
		motion_flags_t pending_flags [$];
		int unsigned   failures;
		int unsigned   results_checked;

		function new();
			threshold = THR_RESET;
			columns_reg = SIZE_RESET;
			rows_reg = SIZE_RESET;
			have_prev = 1'b0;
			failures = 0;
			results_checked = 0;
			clear_frame();
		endfunction

		function void clear_frame();
			foreach (tile_count[i]) tile_count[i] = 0;
			frame_count = 0;
			col_pos = 0;
			row_pos = 0;
			tile_hit = 1'b0;
		endfunction

		function int unsigned clamp_size(logic [8:0] value, int unsigned limit);
			if (value == 0) return 1;
			if (value > limit) return limit;
			return value;
		endfunction

		function int unsigned frame_pixels();
			return clamp_size(columns_reg, MAX_COLUMNS) * clamp_size(rows_reg, MAX_ROWS);
		endfunction

		// A size write that changes a size starts over with a fill frame.
		function void write_reg(cfg_idx_t idx, logic [8:0] value);
			if (idx == CFG_THRESHOLD) begin
				threshold = value[7:0];
				return;
			end
			if (idx == CFG_COLUMNS) begin
				if (value == columns_reg) return;
				columns_reg = value;
			end else begin
				if (value == rows_reg) return;
				rows_reg = value;
			end
			have_prev = 1'b0;
			clear_frame();
		endfunction

		// Advances the state by one accepted pixel and queues the flags of a finished frame.
		function void note_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic inb,
			logic fs);
			int unsigned cols, rows, col, row, addr, slot, luma, stored, diff, tw, th;
			motion_flags_t flags;
			cols = clamp_size(columns_reg, MAX_COLUMNS);
			rows = clamp_size(rows_reg, MAX_ROWS);
			if (fs || col_pos >= cols || row_pos >= rows) clear_frame();
			col = col_pos;
			row = row_pos;
			luma = (77 * int'(r) + 150 * int'(g) + 29 * int'(b) + 128) >> 8;
			addr = row * MAX_COLUMNS + col;
			slot = col / TILE;

			// Compare against the stored frame once a full frame exists.
			if (have_prev) begin
				stored = luma_store[addr];
				diff = (stored > luma) ? stored - luma : luma - stored;
				if (diff >= threshold) begin
					frame_count++;
					if (!inb) tile_count[slot]++;
				end
			end
			luma_store[addr] = 8'(luma);

			// Close the tile on its last pixel, using the real size of edge tiles.
			if ((col % TILE == TILE - 1 || col == cols - 1) &&
				(row % TILE == TILE - 1 || row == rows - 1)) begin
				tw = cols - slot * TILE;
				if (tw > TILE) tw = TILE;
				th = rows - (row - row % TILE);
				if (th > TILE) th = TILE;
				if (have_prev && tile_count[slot] * 4 >= tw * th) tile_hit = 1'b1;
				tile_count[slot] = 0;
			end

			// The last pixel of a frame reports, unless this was the fill frame.
			if (col == cols - 1 && row == rows - 1) begin
				if (have_prev) begin
					flags.frame_triggered = (frame_count * 3 >= cols * rows);
					flags.tile_triggered = tile_hit;
					flags.request_detection = flags.frame_triggered | flags.tile_triggered;
					pending_flags.push_back(flags);
				end
				have_prev = 1'b1;
				clear_frame();
			end else if (col + 1 >= cols) begin
				col_pos = 0;
				row_pos = row + 1;
			end else begin
				col_pos = col + 1;
			end
		endfunction

		function void flag_error(string what);
			failures++;
			if (failures <= MAX_REPORTS) $display("%0t ns: %s", $time, what);
		endfunction

		// Compares one result transaction with the oldest flags owed.
		function void check_result(motion_flags_t got);
			motion_flags_t want;
			if (pending_flags.size() == 0) begin
				flag_error($sformatf("unexpected result req=%b tile=%b frame=%b",
					got.request_detection, got.tile_triggered, got.frame_triggered));
				return;
			end
			want = pending_flags.pop_front();
			results_checked++;
			if (got.request_detection !== want.request_detection ||
				got.tile_triggered !== want.tile_triggered ||
				got.frame_triggered !== want.frame_triggered)
				flag_error($sformatf(
					"result %0d mismatch: expected req=%b tile=%b frame=%b, got req=%b tile=%b frame=%b",
					results_checked, want.request_detection, want.tile_triggered,
					want.frame_triggered, got.request_detection, got.tile_triggered,
					got.frame_triggered));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [7:0] red = 8'd0;
	logic [7:0] green = 8'd0;
	logic [7:0] blue = 8'd0;
	logic inside_box = 1'b0;
	logic frame_start = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic request_detection;
	logic tile_triggered;
	logic frame_triggered;

	motion_flag_tracker sb = new();
	int unsigned send_gap_max = 4;
	int unsigned recv_gap_max = 4;
	bit long_hold_req = 1'b0;
	int unsigned items_sent = 0;
	bit [23:0] pixel_memory [1024];

	tiled_frame_difference_motion #(
		.MAX_COLUMNS(MAX_COLUMNS),
		.MAX_ROWS(MAX_ROWS),
		.TILE_SIZE(TILE)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.red(red),
		.green(green),
		.blue(blue),
		.inside_box(inside_box),
		.frame_start(frame_start),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.request_detection(request_detection),
		.tile_triggered(tile_triggered),
		.frame_triggered(frame_triggered)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Writes one register; the caller lowers the write enable after the last one.
	task automatic write_reg(cfg_idx_t idx, logic [8:0] value);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		sb.write_reg(idx, value);
	endtask

	task automatic set_config(logic [8:0] thr, logic [8:0] cols, logic [8:0] rows);
		write_reg(CFG_THRESHOLD, thr);
		write_reg(CFG_COLUMNS, cols);
		write_reg(CFG_ROWS, rows);
		cfg_write <= 1'b0;
	endtask

	// Offers one pixel after a random gap and holds it until the transaction completes.
	task automatic send_pixel(logic [23:0] rgb, logic inb, logic fs);
		int unsigned gap;
		gap = $urandom_range(0, send_gap_max);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		red <= rgb[23:16];
		green <= rgb[15:8];
		blue <= rgb[7:0];
		inside_box <= inb;
		frame_start <= fs;
		do @(posedge clk); while (in_stall !== 1'b0);
		sb.note_pixel(rgb[23:16], rgb[15:8], rgb[7:0], inb, fs);
		items_sent++;
	endtask

	task automatic send_run(int unsigned count, logic [23:0] rgb, logic inb, logic first_start);
		for (int unsigned k = 0; k < count; k++) send_pixel(rgb, inb, first_start && k == 0);
	endtask

	// Sends one frame: mostly well formed, sometimes without its start flag, cut short,
	// or of random length with scattered starts; unchanged pixels keep their old color.
	task automatic send_frame(int unsigned npix, int unsigned change_pct, int unsigned box_pct);
		int unsigned style, count;
		logic fs, inb;
		style = $urandom_range(0, 99);
		count = npix;
		if (style >= 87 && style < 94 && npix > 1) count = $urandom_range(1, npix - 1);
		if (style >= 94) count = $urandom_range(1, 2 * npix);
		for (int unsigned k = 0; k < count; k++) begin
			if ($urandom_range(0, 99) < change_pct) begin
				case ($urandom_range(0, 15))
					0: pixel_memory[k] = 24'h000000;
					1: pixel_memory[k] = 24'hFFFFFF;
					default: pixel_memory[k] = 24'($urandom);
				endcase
			end
			if (style >= 94) fs = ($urandom_range(0, 15) == 0);
			else fs = (k == 0) && !(style >= 80 && style < 87);
			inb = ($urandom_range(0, 99) < box_pct);
			send_pixel(pixel_memory[k], inb, fs);
		end
	endtask

	// Lets every owed result arrive, then idles to catch a result from a frame that owes none.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (sb.pending_flags.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic int unsigned pick_gap_max();
		case ($urandom_range(0, 3))
			0: return 0;
			1: return 3;
			default: return 18;
		endcase
	endfunction

	// Result side: random stall before each transaction, one long hold on request.
	initial begin
		int unsigned hold;
		motion_flags_t seen;
		wait (arst_n === 1'b1);
		forever begin
			hold = long_hold_req ? LONG_HOLD : $urandom_range(0, recv_gap_max);
			long_hold_req = 1'b0;
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (out_valid !== 1'b1);
			seen = {request_detection, tile_triggered, frame_triggered};
			sb.check_result(seen);
		end
	end

	// Stimulus.
	initial begin
		int unsigned thr, change_pct, box_pct, frames;
		logic [8:0] col_data, row_data;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// A partial frame at the reset sizes, dropped by the size writes that follow.
		send_run(2, 24'h102030, 1'b0, 1'b1);
		wait_idle();

		// Single-pixel frames with a zero threshold and a zero column count.
		set_config(9'd0, 9'd0, 9'd1);
		send_pixel(24'h000000, 1'b0, 1'b1);
		send_pixel(24'hFFFFFF, 1'b0, 1'b1);
		send_pixel(24'hFFFFFF, 1'b1, 1'b0);
		send_pixel(24'h00FF00, 1'b0, 1'b1);
		wait_idle();

		// 2x2 frames at the top threshold: full swing, restart mid-frame, missing start.
		set_config(9'd255, 9'd2, 9'd2);
		send_run(4, 24'h000000, 1'b0, 1'b1);
		send_run(2, 24'hFFFFFF, 1'b0, 1'b1);
		send_run(2, 24'h000000, 1'b0, 1'b0);
		send_run(2, 24'hFFFFFF, 1'b1, 1'b1);
		send_run(4, 24'hFFFFFF, 1'b0, 1'b1);
		send_run(2, 24'h000000, 1'b1, 1'b0);
		send_run(2, 24'hFFFFFF, 1'b0, 1'b0);
		wait_idle();
		items_sent = 0;

		// Back pressure: single-pixel frames at full rate while the result side holds off.
		set_config(9'd20, 9'd1, 9'd1);
		send_gap_max = 0;
		recv_gap_max = 0;
		long_hold_req = 1'b1;
		repeat (60) send_frame(1, 60, 30);
		wait_idle();

		// Widest and tallest frames, with out-of-range size values clamped.
		send_gap_max = pick_gap_max();
		recv_gap_max = pick_gap_max();
		set_config({1'b1, 8'd24}, 9'd511, 9'd0);
		repeat (2) send_frame(sb.frame_pixels(), 50, 20);
		wait_idle();
		set_config(9'd12, 9'd1, 9'd256);
		repeat (2) send_frame(sb.frame_pixels(), 50, 20);

		// Random phases of small frames with varied sizes, thresholds and idling.
		while (items_sent < ITEM_TARGET || sb.results_checked < RESULT_FLOOR) begin
			wait_idle();
			case ($urandom_range(0, 9))
				0: thr = 1;
				1: thr = 255;
				2: thr = 0;
				3, 4: thr = $urandom_range(1, 255);
				default: thr = $urandom_range(4, 48);
			endcase
			case ($urandom_range(0, 9))
				0: col_data = 9'd0;
				1: col_data = 9'd8;
				2: col_data = 9'd16;
				default: col_data = 9'($urandom_range(1, 20));
			endcase
			case ($urandom_range(0, 9))
				0: row_data = 9'd0;
				1: row_data = 9'd8;
				default: row_data = 9'($urandom_range(1, 12));
			endcase
			set_config({1'($urandom_range(0, 1)), 8'(thr)}, col_data, row_data);
			send_gap_max = pick_gap_max();
			recv_gap_max = pick_gap_max();
			frames = $urandom_range(2, 4);
			repeat (frames) begin
				case ($urandom_range(0, 5))
					0: change_pct = 0;
					1: change_pct = 10;
					2: change_pct = 25;
					3: change_pct = 50;
					4: change_pct = 90;
					default: change_pct = 100;
				endcase
				case ($urandom_range(0, 2))
					0: box_pct = 0;
					1: box_pct = 30;
					default: box_pct = 100;
				endcase
				send_frame(sb.frame_pixels(), change_pct, box_pct);
			end
		end

		wait_idle();
		if (sb.failures == 0 && sb.pending_flags.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	// Hard limit on the run.
	initial begin
		#2_000_000;
		$display("FAIL");
		$finish;
	end

endmodule
